// File: rtl/fir_convolution_loadable_taps_defines.svh
// Assertion macros used by the FIR convolution RTL.
`ifndef FIR_CONVOLUTION_LOADABLE_TAPS_DEFINES_SVH
`define FIR_CONVOLUTION_LOADABLE_TAPS_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled in reset.
`define FCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, disabled in reset.
`define FCL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FCL_ASSERT_IMP(lbl, ante, cons, msg)
`define FCL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/fcl_pkg.sv
// Shared types and constants of the FIR convolution block.
package fcl_pkg;

	localparam int COEF_W      = 16;
	localparam int COEF_FRAC   = 15;
	localparam int IDX_W       = 8;
	localparam int TAP_COUNT_W = 9;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 9'd256;

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef struct packed {
		logic clear;
		logic vld;
	} mac_ctl_t;

endpackage

// File: rtl/fcl_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module fcl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/fcl_mac.sv
// Multiply-accumulate with floor scaling and saturation of the sum.
module fcl_mac #(
	parameter int MAX_TAPS    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fcl_pkg::mac_ctl_t      ctl,
	input  logic [SAMPLE_BITS-1:0] sample_s1,
	input  logic [fcl_pkg::COEF_W-1:0] coef_s1,
	output logic                   busy,
	output logic [SAMPLE_BITS-1:0] result,
	output logic                   sat
);

	localparam int PROD_W = SAMPLE_BITS + fcl_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1);
	localparam int TOP_LO = fcl_pkg::COEF_FRAC + SAMPLE_BITS - 1;

	logic                     mul_vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-TOP_LO-1:0]  top_bits;
	logic                     ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s2 <= 1'b0;
			prod_s2    <= '0;
			acc_q      <= '0;
		end else begin
			mul_vld_s2 <= ctl.vld;
			if (ctl.vld) begin
				prod_s2 <= $signed(sample_s1) * $signed(coef_s1);
			end
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (mul_vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Floor shift is a bit select; clip when the result's sign bit and the bits above it disagree.
	assign top_bits = acc_q[ACC_W-1:TOP_LO];
	assign ovf      = !((&top_bits) || (~|top_bits));
	assign sat      = ovf;
	assign busy     = mul_vld_s2;

	always_comb begin
		if (!ovf) begin
			result = acc_q[TOP_LO:fcl_pkg::COEF_FRAC];
		end else if (acc_q[ACC_W-1]) begin
			result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

endmodule

// File: rtl/fir_convolution_loadable_taps.sv
// Top level: FIR convolution with a loadable coefficient memory.
//
//  channel     | dir | width              | contents (low bit up)
//  ------------+-----+--------------------+-----------------------------------------
//  s_axis      | in  | tdata 40 (default) | sample_in, coef_index, coef_value; tuser cmd;
//              |     |                    | tlast last_in
//  m_axis      | out | tdata 16 (default) | filtered_out; tuser saturated; tlast last_out
//  cfg         | in  | 9                  | tap_count, written when cfg_we is high
//
//  A coefficient-load word is written to the coefficient memory; the block stays ready. A
//  filter word reads N history and coefficient pairs, N = min(tap_count, MAX_TAPS, samples
//  seen since reset), leaves the read loop, drains the multiply-accumulate, loads the result.
//  Reset clears the history pointer and the fill count; history entries beyond the
//  fill count are never summed, so the history memory needs no clearing pass.
//  The result waits in an output register; a new input word is taken while it
//  waits, and the block holds its finished sum until the output slot frees.
`include "fir_convolution_loadable_taps_defines.svh"

module fir_convolution_loadable_taps #(
	parameter int MAX_TAPS    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// tap_count register
	input  logic                              cfg_we,
	input  logic [fcl_pkg::TAP_COUNT_W-1:0]   cfg_data,
	// input words
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// sample_in, coef_index, coef_value, zero pad
	input  logic [((SAMPLE_BITS+24+7)/8)*8-1:0] s_axis_tdata,
	// cmd
	input  logic                              s_axis_tuser,
	// last_in
	input  logic                              s_axis_tlast,
	// result words
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// filtered_out, zero pad
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,
	// saturated
	output logic                              m_axis_tuser,
	// last_out
	output logic                              m_axis_tlast
);

	localparam int AW     = $clog2(MAX_TAPS);
	localparam int CNT_W  = $clog2(MAX_TAPS + 1);
	localparam int TC_W   = fcl_pkg::TAP_COUNT_W;
	localparam int CMP_W  = (CNT_W > TC_W) ? CNT_W : TC_W;
	localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int IDX_LO = SAMPLE_BITS;
	localparam int VAL_LO = SAMPLE_BITS + fcl_pkg::IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t                       state_q;
	logic [TC_W-1:0]              tap_count_q;
	logic [AW-1:0]                ptr_q;
	logic [AW-1:0]                rd_ptr_q;
	logic [CNT_W-1:0]             fill_q;
	logic [CNT_W-1:0]             j_q;
	logic [CNT_W-1:0]             taps_eff_q;
	logic                         rd_vld_s1;
	logic                         last_q;
	logic                         out_vld_q;
	logic [SAMPLE_BITS-1:0]       out_data_q;
	logic                         out_sat_q;
	logic                         out_last_q;

	logic                         in_fire;
	logic                         load_fire;
	logic                         filt_fire;
	logic                         coef_we;
	logic [SAMPLE_BITS-1:0]       sample_in;
	logic [fcl_pkg::IDX_W-1:0]    coef_index;
	logic [fcl_pkg::COEF_W-1:0]   coef_value;
	logic [CNT_W-1:0]             fill_nxt;
	logic [CMP_W-1:0]             tap_cap;
	logic [CMP_W-1:0]             taps_lim;
	logic                         issue;
	logic                         done;
	logic                         out_load;
	logic [SAMPLE_BITS-1:0]       hist_rdata;
	logic [fcl_pkg::COEF_W-1:0]   coef_rdata;
	fcl_pkg::mac_ctl_t            mac_ctl;
	logic                         mac_busy;
	logic [SAMPLE_BITS-1:0]       mac_result;
	logic                         mac_sat;

	// Unpack the input word.
	assign sample_in  = s_axis_tdata[SAMPLE_BITS-1:0];
	assign coef_index = s_axis_tdata[VAL_LO-1:IDX_LO];
	assign coef_value = s_axis_tdata[VAL_LO+fcl_pkg::COEF_W-1:VAL_LO];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign load_fire     = in_fire && (s_axis_tuser == fcl_pkg::CMD_LOAD);
	assign filt_fire     = in_fire && (s_axis_tuser == fcl_pkg::CMD_FILTER);
	// Drop loads aimed past the end of the coefficient memory.
	assign coef_we       = load_fire && (int'(coef_index) < MAX_TAPS);

	// Samples seen so far, saturating at the history depth; counts this sample.
	assign fill_nxt = (fill_q == CNT_W'(MAX_TAPS)) ? fill_q : fill_q + 1'b1;

	// Taps summed: tap_count clamped to MAX_TAPS, then to the filled history.
	always_comb begin
		tap_cap  = (CMP_W'(tap_count_q) > CMP_W'(MAX_TAPS)) ?
			CMP_W'(MAX_TAPS) : CMP_W'(tap_count_q);
		taps_lim = (tap_cap > CMP_W'(fill_nxt)) ? CMP_W'(fill_nxt) : tap_cap;
	end

	assign issue    = (state_q == ST_RUN) && (j_q != taps_eff_q);
	assign done     = (state_q == ST_DRAIN) && !rd_vld_s1 && !mac_busy;
	assign out_load = done && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_count_q <= fcl_pkg::TAP_COUNT_RESET;
			ptr_q       <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			j_q         <= '0;
			taps_eff_q  <= '0;
			rd_vld_s1   <= 1'b0;
			last_q      <= 1'b0;
			out_vld_q   <= 1'b0;
			out_data_q  <= '0;
			out_sat_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tap_count_q <= cfg_data;
			end
			rd_vld_s1 <= issue;

			unique case (state_q)
				ST_IDLE: begin
					if (filt_fire) begin
						// The sample lands in history now; reads start next cycle,
						// so the newest entry is seen without forwarding.
						rd_ptr_q   <= ptr_q;
						ptr_q      <= (ptr_q == AW'(MAX_TAPS - 1)) ? '0 : ptr_q + 1'b1;
						fill_q     <= fill_nxt;
						j_q        <= '0;
						taps_eff_q <= CNT_W'(taps_lim);
						last_q     <= s_axis_tlast;
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						// Advance the tap index; walk the history back one slot.
						j_q      <= j_q + 1'b1;
						rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_q - 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Output slot: load a finished sum, or drop the word once taken.
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_data_q <= mac_result;
				out_sat_q  <= mac_sat;
				out_last_q <= last_q;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	fcl_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (filt_fire),
		.waddr (ptr_q),
		.wdata (sample_in),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (hist_rdata)
	);

	fcl_ram #(
		.WIDTH (fcl_pkg::COEF_W),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (AW'(coef_index)),
		.wdata (coef_value),
		.re    (issue),
		.raddr (j_q[AW-1:0]),
		.rdata (coef_rdata)
	);

	assign mac_ctl.clear = filt_fire;
	assign mac_ctl.vld   = rd_vld_s1;

	fcl_mac #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.sample_s1 (hist_rdata),
		.coef_s1   (coef_rdata),
		.busy      (mac_busy),
		.result    (mac_result),
		.sat       (mac_sat)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);
	assign m_axis_tuser  = out_sat_q;
	assign m_axis_tlast  = out_last_q;

	`FCL_ASSERT_IMP(a_idle_pipe_empty, state_q == ST_IDLE, !rd_vld_s1 && !mac_busy, "MAC pipeline busy while idle")
	`FCL_ASSERT_IMP(a_tap_bound, state_q == ST_RUN, j_q <= taps_eff_q, "tap index ran past tap count")
	`FCL_ASSERT_IMP(a_taps_filled, state_q != ST_IDLE, taps_eff_q <= fill_q, "summing unfilled history")
	`FCL_ASSERT_IMP(a_no_overwrite, out_load, !out_vld_q || m_axis_tready, "result overwritten before taken")
	`FCL_ASSERT_NXT(a_fill_bound, filt_fire, fill_q <= CNT_W'(MAX_TAPS), "fill count past history depth")

endmodule
